### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the top-k selection block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is high.
`define TKS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Payload of a stalled channel holds until the transaction completes.
`define TKS_ASSERT_HOLD(lbl, clk, rst, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

### hw/rtl/tks_pkg.sv
// Shared constants, types and command/status structs of the top-k selection block.
// No dependencies; compiled before every other file.
`timescale 1ns / 1ps

package tks_pkg;

  localparam int VALUE_W    = 32;
  localparam int K_MAX      = 16;
  localparam int ROW_MAX    = 4096;
  localparam int POS_W      = $clog2(ROW_MAX);
  localparam int KEPT_POS_W = 12;
  localparam int CNT_W      = $clog2(K_MAX + 1);
  localparam int IDX_W      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KEEP_W     = 5;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_WANT_LARGEST = REG_IDX_W'(1);

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = KEEP_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] keep_eff;
    logic             want_largest;
  } cfg_t;

  typedef struct packed {
    logic insert;
    logic trim;
    logic load_out;
    logic clear_row;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

### hw/rtl/tks_if.sv
// Stream channel interfaces: row elements in, kept results out.
// Depends on tks_pkg for field widths.
`timescale 1ns / 1ps

interface tks_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tks_pkg::VALUE_W-1:0] sample_value;
  logic                              row_end;

  modport source (output valid, sample_value, row_end, input ready);
  modport sink   (input valid, sample_value, row_end, output ready);
endinterface

interface tks_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tks_pkg::VALUE_W-1:0]    kept_value;
  logic        [tks_pkg::KEPT_POS_W-1:0] kept_position;
  logic                                 final_result;

  modport source (output valid, kept_value, kept_position, final_result, input ready);
  modport sink   (input valid, kept_value, kept_position, final_result, output ready);
endinterface

### hw/rtl/topk_select_sorted_core.sv
// Top-k selection over a streamed row of signed values, best first on row end.
// Depends on tks_pkg, tks_if, tks_regs, tks_ctrl and tks_dp.
`timescale 1ns / 1ps

// Keeps the k largest (want_largest=1) or k smallest row elements with their
// row positions; on equal values the earlier element stays. A row of 16
// compare-and-shift cells, held sorted by (value, position), inserts and
// evicts in the cycle of the transaction. After the element that carries
// row_end, min(k, row length) results follow, one a cycle while the output
// is not stalled, through the single output register, with the input held
// off until the last of them is loaded. If keep_count is lowered in the
// middle of a row, the worst entries are dropped until the set fits the new
// k before the next element is taken. Configuration is written over the APB
// port (keep_count at 0x0, want_largest at 0x4); the user is to write it
// only while idle, as the block itself has no guard for this.
module topk_select_sorted_core (
  input  logic                        clk,
  input  logic                        rst,
  tks_in_if.sink                      in_ch,
  tks_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::PADDR_W-1:0] paddr,
  input  logic [tks_pkg::PDATA_W-1:0] pwdata,
  output logic [tks_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tks_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  tks_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .row_end  (in_ch.row_end),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tks_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .sample_value  (in_ch.sample_value),
    .row_end       (in_ch.row_end),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .kept_value    (out_ch.kept_value),
    .kept_position (out_ch.kept_position),
    .final_result  (out_ch.final_result)
  );

endmodule

### hw/rtl/tks_regs.sv
// APB-style configuration registers: keep count and selection mode.
// Depends on tks_pkg; produces the clamped k used by the datapath.
`timescale 1ns / 1ps

module tks_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tks_pkg::PADDR_W-1:0]   paddr,
  input  logic [tks_pkg::PDATA_W-1:0]   pwdata,
  output logic [tks_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tks_pkg::cfg_t                 cfg
);
  import tks_pkg::*;

  logic [KEEP_W-1:0]    keep_count;
  logic                 want_largest;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count   <= KEEP_COUNT_RST;
      want_largest <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEEP_COUNT:   keep_count   <= pwdata[KEEP_W-1:0];
        REG_WANT_LARGEST: want_largest <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEEP_COUNT:   prdata = PDATA_W'(keep_count);
      REG_WANT_LARGEST: prdata = PDATA_W'(want_largest);
      default:          prdata = '0;
    endcase
  end

  // zero acts as one, anything above the store depth acts as the depth
  always_comb begin
    cfg.want_largest = want_largest;
    if (keep_count == '0) begin
      cfg.keep_eff = CNT_W'(1);
    end else if (32'(keep_count) > 32'(K_MAX)) begin
      cfg.keep_eff = CNT_W'(K_MAX);
    end else begin
      cfg.keep_eff = CNT_W'(keep_count);
    end
  end

endmodule

### hw/rtl/tks_ctrl.sv
// Controller: accepts row elements, trims the kept set and sequences the output.
// Depends on tks_pkg; drives tks_dp through dp_cmd_t and reads dp_status_t.
`timescale 1ns / 1ps

module tks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                row_end,
  output logic                in_ready,
  input  tks_pkg::dp_status_t status,
  output tks_pkg::dp_cmd_t    cmd
);
  import tks_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !status.over && row_end) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        // k lowered mid-row: once an element waits, drop one worst entry a cycle
        // under the mode in force at that point, then take the element
        in_ready   = !status.over;
        cmd.trim   = in_valid && status.over;
        cmd.insert = in_valid && !status.over;
      end
      ST_EMIT: begin
        cmd.load_out  = status.out_free;
        cmd.clear_row = status.out_free && status.emit_last;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/tks_dp.sv
// Datapath: kept set as a row of cells sorted by (value, position) ascending,
// insert/evict as a single registered update, output register. Depends on tks_pkg.
`timescale 1ns / 1ps

module tks_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  tks_pkg::cfg_t                      cfg,
  input  tks_pkg::dp_cmd_t                   cmd,
  output tks_pkg::dp_status_t                status,
  input  logic signed [tks_pkg::VALUE_W-1:0] sample_value,
  input  logic                               row_end,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [tks_pkg::VALUE_W-1:0] kept_value,
  output logic [tks_pkg::KEPT_POS_W-1:0]     kept_position,
  output logic                               final_result
);
  import tks_pkg::*;

  logic signed [VALUE_W-1:0] vals      [K_MAX];
  logic        [POS_W-1:0]   poss      [K_MAX];
  logic signed [VALUE_W-1:0] vals_next [K_MAX];
  logic        [POS_W-1:0]   poss_next [K_MAX];
  logic signed [VALUE_W-1:0] up_v      [K_MAX];
  logic        [POS_W-1:0]   up_p      [K_MAX];
  logic signed [VALUE_W-1:0] dn_v      [K_MAX];
  logic        [POS_W-1:0]   dn_p      [K_MAX];

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] emit_cnt;
  logic [CNT_W-1:0] rd_cnt;
  logic [IDX_W-1:0] rd_idx;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] row_pos_next;

  logic [K_MAX-1:0] le;
  logic [K_MAX-1:0] gtv;
  logic [K_MAX:0]   le_lo;
  logic [K_MAX:0]   le_hi;
  logic             full;
  logic             better_low;
  logic             better_high;
  logic             do_up;
  logic             do_dn;
  logic             do_drop;

  // Largest mode evicts the bottom cell, smallest mode the top one.
  // In smallest mode with a full set the top cell is left out of the compare
  // so the shift-up insert overwrites it.
  always_comb begin
    full = (fill >= cfg.keep_eff);
    lim  = (full && !cfg.want_largest) ? fill - CNT_W'(1) : fill;
    for (int i = 0; i < K_MAX; i++) begin
      le[i]  = (CNT_W'(i) < lim) &&
               ((vals[i] < sample_value) ||
                ((vals[i] == sample_value) && (poss[i] <= row_pos)));
      gtv[i] = (CNT_W'(i) < fill) && (vals[i] > sample_value);
    end
    le_lo       = {le, 1'b1};
    le_hi       = {1'b0, le};
    better_low  = sample_value > vals[0];
    better_high = |gtv;
  end

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      // insert with cells above the slot moving up
      if (le[i]) begin
        up_v[i] = vals[i];
        up_p[i] = poss[i];
      end else if (le_lo[i]) begin
        up_v[i] = sample_value;
        up_p[i] = row_pos;
      end else if (i > 0) begin
        up_v[i] = vals[i-1];
        up_p[i] = poss[i-1];
      end else begin
        up_v[i] = vals[i];
        up_p[i] = poss[i];
      end
      // bottom cell evicted, cells below the slot moving down
      if (le_hi[i+1] && (i < K_MAX - 1)) begin
        dn_v[i] = vals[i+1];
        dn_p[i] = poss[i+1];
      end else if (le[i]) begin
        dn_v[i] = sample_value;
        dn_p[i] = row_pos;
      end else begin
        dn_v[i] = vals[i];
        dn_p[i] = poss[i];
      end
    end
  end

  always_comb begin
    do_up   = cmd.insert && (!full || (!cfg.want_largest && better_high));
    do_dn   = cmd.insert && full && cfg.want_largest && better_low;
    do_drop = cmd.trim && cfg.want_largest;
    for (int i = 0; i < K_MAX; i++) begin
      priority if (do_up) begin
        vals_next[i] = up_v[i];
        poss_next[i] = up_p[i];
      end else if (do_dn) begin
        vals_next[i] = dn_v[i];
        poss_next[i] = dn_p[i];
      end else if (do_drop && (i < K_MAX - 1)) begin
        vals_next[i] = vals[i+1];
        poss_next[i] = poss[i+1];
      end else begin
        vals_next[i] = vals[i];
        poss_next[i] = poss[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < K_MAX; i++) begin
      vals[i] <= vals_next[i];
      poss[i] <= poss_next[i];
    end
  end

  always_comb begin
    fill_next = fill;
    priority if (cmd.clear_row) begin
      fill_next = '0;
    end else if (cmd.insert && !full) begin
      fill_next = fill + CNT_W'(1);
    end else if (cmd.trim) begin
      fill_next = fill - CNT_W'(1);
    end

    row_pos_next = row_pos;
    priority if (cmd.clear_row) begin
      row_pos_next = '0;
    end else if (cmd.insert && !row_end) begin
      row_pos_next = (row_pos == POS_W'(ROW_MAX - 1)) ? '0 : row_pos + POS_W'(1);
    end
  end

  // best first: top down in largest mode, bottom up in smallest mode
  assign rd_cnt = cfg.want_largest ? fill - CNT_W'(1) - emit_cnt : emit_cnt;
  assign rd_idx = rd_cnt[IDX_W-1:0];

  assign status.over      = fill > cfg.keep_eff;
  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = (emit_cnt == fill - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      row_pos   <= '0;
      emit_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      fill    <= fill_next;
      row_pos <= row_pos_next;
      if (cmd.load_out) begin
        emit_cnt  <= status.emit_last ? '0 : emit_cnt + CNT_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kept_value    <= vals[rd_idx];
      kept_position <= KEPT_POS_W'(poss[rd_idx]);
      final_result  <= status.emit_last;
    end
  end

endmodule

### hw/rtl/tks_checker.sv
// Port-level checks of topk_select_sorted_core, attached by bind.
// Depends on tks_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tks_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               row_end,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [tks_pkg::VALUE_W-1:0] kept_value,
  input logic [tks_pkg::KEPT_POS_W-1:0]     kept_position,
  input logic                               final_result
);
  import tks_pkg::*;

  `TKS_ASSERT_HOLD(a_out_hold, clk, rst, out_valid, out_ready, {kept_value, kept_position, final_result}, "stalled result changed")

  // a row end starts the result phase, input closes right away
  `TKS_ASSERT(a_row_end_blocks, clk, rst, (in_valid && in_ready && row_end) |=> !in_ready, "input open after row end")

  // a fresh result is only loaded during the result phase
  `TKS_ASSERT(a_result_in_emit, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result loaded outside result phase")

  // while a non-final result is pending the row's results are not done, input stays closed
  `TKS_ASSERT(a_final_stops, clk, rst, (out_valid && !final_result) |-> !in_ready, "input open before final result")

endmodule

bind topk_select_sorted_core tks_checker u_tks_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .row_end       (in_ch.row_end),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .kept_value    (out_ch.kept_value),
  .kept_position (out_ch.kept_position),
  .final_result  (out_ch.final_result)
);
